// File: rtl/core/mfa_pkg.sv
// ----------------------------------------------------------------------------
// mfa_pkg: shared types and constants for the max-flow engine
// Node counts, matrix widths, request and result words, and the ALU control.
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int NODES     = 128;
  localparam int NODE_BITS = 7;
  localparam int CAP_BITS  = 16;
  localparam int RES_BITS  = 17;
  localparam int ADDR_BITS = 2 * NODE_BITS;
  localparam int SP_BITS   = NODE_BITS + 1;

  // Request codes.
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [NODE_BITS-1:0] from_node;
    logic [NODE_BITS-1:0] to_node;
    logic [CAP_BITS-1:0]  capacity;
    logic [NODE_BITS-1:0] source_node;
    logic [NODE_BITS-1:0] sink_node;
  } in_word_t;

  typedef struct packed {
    logic [31:0] max_flow;
    logic [31:0] rounds;
    logic        bad_request;
  } out_word_t;

  typedef enum logic [1:0] {
    ALU_MIN = 2'd0,
    ALU_SUB = 2'd1,
    ALU_ADD = 2'd2,
    ALU_NZ  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [RES_BITS-1:0] opa;
    logic [RES_BITS-1:0] opb;
  } alu_ctl_t;

endpackage

// File: rtl/core/max_flow_dfs_augment.sv
// ----------------------------------------------------------------------------
// max_flow_dfs_augment: Ford-Fulkerson max-flow engine, depth-first search
// Residual matrix in on-chip memory, one shared ALU under a sequencer.
// ----------------------------------------------------------------------------
// Usage: each input word on in_word (valid/stall) is a request. A clear
// request zeroes the whole matrix. A load request writes an edge and zeroes
// its reverse entry. Neither gives a result. A compute request runs rounds of
// depth-first search and augmentation, then emits one output word with the
// total flow and round count; a request with source equal to sink gives a
// flagged word at once. Compute time is data dependent: each popped node
// scans its whole matrix row, one neighbor at a time, through the single
// read port, and each augmenting path is walked twice: once for its
// bottleneck and once to update residuals. in_stall is high whenever the
// sequencer is busy. After reset the matrix is cleared before a word is taken.
// The result sits in an output register until taken; a new request may be
// accepted meanwhile, and a second result waits while out_stall is high.
// ----------------------------------------------------------------------------
module max_flow_dfs_augment import mfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_LOAD2 = 16'h0004,
    S_START = 16'h0008,
    S_POP   = 16'h0010,
    S_POPW  = 16'h0020,
    S_SRD   = 16'h0040,
    S_SCHK  = 16'h0080,
    S_B_PRD = 16'h0100,
    S_B_PWT = 16'h0200,
    S_B_MWT = 16'h0400,
    S_A_PRD = 16'h0800,
    S_A_PWT = 16'h1000,
    S_A_FWT = 16'h2000,
    S_A_BWT = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  state_t state;

  // Memories and their read registers.
  logic [RES_BITS-1:0]  mat [2**ADDR_BITS];
  logic [NODE_BITS-1:0] pred [NODES];
  logic [NODE_BITS-1:0] stack [NODES];
  logic [RES_BITS-1:0]  mat_q;
  logic [NODE_BITS-1:0] pred_q;
  logic [NODE_BITS-1:0] stack_q;

  logic                 mat_we;
  logic [ADDR_BITS-1:0] mat_waddr;
  logic [ADDR_BITS-1:0] mat_raddr;
  logic [RES_BITS-1:0]  mat_wdata;
  logic [NODE_BITS-1:0] stack_raddr;

  // Sequencer registers.
  logic [NODES-1:0]     pv;
  logic [NODES-1:0]     visited;
  logic [SP_BITS-1:0]   sp;
  logic [SP_BITS-1:0]   sp_dec;
  logic [NODE_BITS-1:0] src;
  logic [NODE_BITS-1:0] dst;
  logic [NODE_BITS-1:0] u;
  logic [NODE_BITS-1:0] i;
  logic [NODE_BITS-1:0] a;
  logic [NODE_BITS-1:0] b;
  logic [NODE_BITS-1:0] ld_from;
  logic [NODE_BITS-1:0] ld_to;
  logic [ADDR_BITS-1:0] caddr;
  logic [RES_BITS-1:0]  bn;
  logic [31:0]          flow;
  logic [31:0]          rounds;
  logic                 bad;

  alu_ctl_t            alu_ctl;
  logic [RES_BITS-1:0] alu_res;
  logic                alu_nz;
  logic                in_acc;

  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign sp_dec      = sp - 1'b1;
  assign stack_raddr = sp_dec[NODE_BITS-1:0];

  mfa_alu u_alu (
    .ctl (alu_ctl),
    .res (alu_res),
    .nz  (alu_nz)
  );

  // Operation selection for the shared ALU; the operands are always mat_q and bn.
  always_comb begin
    alu_ctl.op  = ALU_NZ;
    alu_ctl.opa = mat_q;
    alu_ctl.opb = bn;
    case (state)
      S_B_MWT: alu_ctl.op = ALU_MIN;
      S_A_FWT: alu_ctl.op = ALU_SUB;
      S_A_BWT: alu_ctl.op = ALU_ADD;
      default: alu_ctl.op = ALU_NZ;
    endcase
  end

  // Matrix port addresses and write data.
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = caddr;
    mat_wdata = '0;
    mat_raddr = {u, i};
    case (state)
      S_CLEAR: mat_we = 1'b1;
      S_IDLE: begin
        mat_we    = in_acc && (in_word.mode == MODE_LOAD);
        mat_waddr = {in_word.from_node, in_word.to_node};
        mat_wdata = {1'b0, in_word.capacity};
      end
      S_LOAD2: begin
        mat_we    = 1'b1;
        mat_waddr = {ld_to, ld_from};
      end
      S_B_PWT, S_A_PWT: mat_raddr = {pred_q, b};
      S_A_FWT: begin
        mat_we    = 1'b1;
        mat_waddr = {a, b};
        mat_wdata = alu_res;
        mat_raddr = {b, a};
      end
      S_A_BWT: begin
        mat_we    = 1'b1;
        mat_waddr = {b, a};
        mat_wdata = alu_res;
      end
      default: mat_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat[mat_waddr] <= mat_wdata;
    end
    mat_q <= mat[mat_raddr];
  end

  // Predecessor and stack memories: one write and one read address each.
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      pred[src]  <= src;
      stack['0]  <= src;
    end else if (state == S_SCHK && alu_nz && !pv[i] && sp < SP_BITS'(NODES)) begin
      pred[i]              <= u;
      stack[sp[NODE_BITS-1:0]] <= i;
    end
    pred_q  <= pred[b];
    stack_q <= stack[stack_raddr];
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      caddr     <= '0;
      out_valid <= 1'b0;
      pv        <= '0;
      visited   <= '0;
      sp        <= '0;
    end else begin
      // A taken word frees the output unless a new one is loaded now.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          caddr <= caddr + 1'b1;
          if (caddr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (in_word.mode)
              MODE_CLEAR: begin
                caddr <= '0;
                state <= S_CLEAR;
              end
              MODE_LOAD: begin
                ld_from <= in_word.from_node;
                ld_to   <= in_word.to_node;
                state   <= S_LOAD2;
              end
              MODE_COMPUTE: begin
                src    <= in_word.source_node;
                dst    <= in_word.sink_node;
                flow   <= '0;
                rounds <= '0;
                bad    <= (in_word.source_node == in_word.sink_node);
                state  <= (in_word.source_node == in_word.sink_node) ? S_DONE : S_START;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD2: state <= S_IDLE;
        S_START: begin
          rounds       <= rounds + 1'b1;
          pv           <= NODES'(1) << src;
          visited      <= '0;
          sp           <= SP_BITS'(1);
          state        <= S_POP;
        end
        S_POP: begin
          if (pv[dst]) begin
            bn    <= '1;
            b     <= dst;
            state <= S_B_PRD;
          end else if (sp == '0) begin
            state <= S_DONE;
          end else begin
            sp    <= sp_dec;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          u <= stack_q;
          if (visited[stack_q]) begin
            state <= S_POP;
          end else begin
            visited[stack_q] <= 1'b1;
            i                <= '0;
            state            <= S_SRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          // Push each neighbor with residual left and no predecessor yet, while the stack has room.
          if (alu_nz && !pv[i] && sp < SP_BITS'(NODES)) begin
            pv[i] <= 1'b1;
            sp    <= sp + 1'b1;
          end
          i     <= i + 1'b1;
          state <= (i == NODE_BITS'(NODES - 1)) ? S_POP : S_SRD;
        end
        S_B_PRD: state <= S_B_PWT;
        S_B_PWT: begin
          a <= pred_q;
          if (pred_q == b) begin
            b     <= dst;
            state <= S_A_PRD;
          end else begin
            state <= S_B_MWT;
          end
        end
        S_B_MWT: begin
          bn    <= alu_res;
          b     <= a;
          state <= S_B_PRD;
        end
        S_A_PRD: state <= S_A_PWT;
        S_A_PWT: begin
          a <= pred_q;
          if (pred_q == b) begin
            flow  <= flow + 32'(bn);
            state <= S_START;
          end else begin
            state <= S_A_FWT;
          end
        end
        S_A_FWT: state <= S_A_BWT;
        S_A_BWT: begin
          b     <= a;
          state <= S_A_PRD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_word.max_flow    <= bad ? 32'd0 : flow;
            out_word.rounds      <= bad ? 32'd0 : rounds;
            out_word.bad_request <= bad;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_BITS'(NODES)) else $error("stack pointer beyond node count");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bad_request |-> out_word.max_flow == 0 && out_word.rounds == 0)
    else $error("flagged word carries nonzero results");

  a_bn_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_A_FWT |-> bn != '0) else $error("augmenting with zero bottleneck");

  a_scan_next: assert property (@(posedge clk) disable iff (rst)
    state == S_SCHK |=> state == S_SRD || state == S_POP)
    else $error("row scan left unexpectedly");

endmodule

// File: rtl/core/mfa_alu.sv
// ----------------------------------------------------------------------------
// mfa_alu: shared residual arithmetic unit
// One minimum, subtract, add or nonzero test on residual values per cycle.
// ----------------------------------------------------------------------------
module mfa_alu import mfa_pkg::*; (
  input  alu_ctl_t            ctl,
  output logic [RES_BITS-1:0] res,
  output logic                nz
);

  // The selected operation on the two operands.
  always_comb begin
    nz = (ctl.opa != '0);
    case (ctl.op)
      ALU_MIN: res = (ctl.opb < ctl.opa) ? ctl.opb : ctl.opa;
      ALU_SUB: res = ctl.opa - ctl.opb;
      ALU_ADD: res = ctl.opa + ctl.opb;
      default: res = ctl.opa;
    endcase
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max-flow engine
// A driver feeds clear, load, compute and ignored words from a queue. Each accepted
// word runs through a behavioral max-flow predictor. A monitor compares every
// result word with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mfa_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int IDLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  max_flow_dfs_augment dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // Predictor state: residual capacities plus search scratch.
  int unsigned resid [NODES][NODES];
  int unsigned pred_node [NODES];
  bit          pred_set [NODES];
  bit          seen [NODES];
  int unsigned dfs_stack [NODES];

  in_word_t  pending_words [$];
  out_word_t flow_expect [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        computes_sent = 0;
  int        cycle_no = 0;
  int        idle_cycles = 0;
  int        hold_cnt = 0;
  bit        hold_done = 0;

  // Quiet window with no random idling on either side.
  function automatic bit take_break();
    if (cycle_no > 100000 && cycle_no < 160000) return 1'b0;
    return ($urandom_range(0, 99) < 6);
  endfunction

  function automatic bit search_path(int unsigned s, int unsigned t);
    int unsigned sp, u;
    for (int i = 0; i < NODES; i++) begin
      pred_set[i] = 0;
      seen[i] = 0;
    end
    sp = 0;
    dfs_stack[sp++] = s;
    pred_node[s] = s;
    pred_set[s] = 1;
    while (sp > 0 && !pred_set[t]) begin
      u = dfs_stack[--sp];
      if (!seen[u]) begin
        seen[u] = 1;
        for (int i = 0; i < NODES; i++) begin
          if (resid[u][i] > 0 && !pred_set[i] && sp < NODES) begin
            dfs_stack[sp++] = i;
            pred_node[i] = u;
            pred_set[i] = 1;
          end
        end
      end
    end
    return pred_set[t];
  endfunction

  // Push the path bottleneck along the predecessor chain; returns the amount.
  function automatic int unsigned push_bottleneck(int unsigned t);
    int unsigned a, b, bn, guard;
    bn = 32'hFFFF_FFFF;
    b = t;
    a = pred_node[t];
    for (guard = 0; a != b && guard < NODES; guard++) begin
      if (resid[a][b] < bn) bn = resid[a][b];
      b = a;
      a = pred_node[b];
    end
    b = t;
    a = pred_node[t];
    for (guard = 0; a != b && guard < NODES; guard++) begin
      resid[a][b] -= bn;
      resid[b][a] += bn;
      b = a;
      a = pred_node[b];
    end
    return bn;
  endfunction

  task automatic flow_predict(input in_word_t w);
    out_word_t r;
    int unsigned s, t;
    r = '0;
    s = 32'(w.source_node);
    t = 32'(w.sink_node);
    case (w.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < NODES; i++)
          for (int j = 0; j < NODES; j++) resid[i][j] = 0;
      end
      MODE_LOAD: begin
        resid[w.from_node][w.to_node] = 32'(w.capacity);
        resid[w.to_node][w.from_node] = 0;
      end
      MODE_COMPUTE: begin
        if (s == t) begin
          r.bad_request = 1'b1;
        end else begin
          forever begin
            r.rounds++;
            if (!search_path(s, t)) break;
            r.max_flow += push_bottleneck(t);
          end
        end
        flow_expect.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Driver: accept the current word, predict it, then offer the next.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) flow_predict(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && !take_break()) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result; one long hold-off after some results.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (flow_expect.size() == 0) begin
          $display("unexpected result word: flow %0d rounds %0d", out_word.max_flow,
                   out_word.rounds);
          mismatches++;
        end else begin
          out_word_t want;
          want = flow_expect.pop_front();
          if (out_word.max_flow !== want.max_flow)
            report("max_flow", out_word.max_flow, want.max_flow);
          if (out_word.rounds !== want.rounds)
            report("rounds", out_word.rounds, want.rounds);
          if (out_word.bad_request !== want.bad_request)
            report("bad_request", 32'(out_word.bad_request), 32'(want.bad_request));
        end
        results_seen <= results_seen + 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (results_seen == 20 && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= take_break();
      end
    end
  end

  // Watchdog on cycles with no word moving either way.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic [1:0] m, int f, int t, int c, int s, int k);
    in_word_t w;
    w.mode = m;
    w.from_node = NODE_BITS'(f);
    w.to_node = NODE_BITS'(t);
    w.capacity = CAP_BITS'(c);
    w.source_node = NODE_BITS'(s);
    w.sink_node = NODE_BITS'(k);
    return w;
  endfunction

  function automatic int rnd(int hi);
    return $urandom_range(0, hi);
  endfunction

  task automatic add_load(int f, int t, int c);
    pending_words.push_back(make_word(MODE_LOAD, f, t, c, rnd(127), rnd(127)));
  endtask

  task automatic add_compute(int s, int k);
    pending_words.push_back(make_word(MODE_COMPUTE, rnd(127), rnd(127), rnd(65535), s, k));
    computes_sent++;
  endtask

  task automatic add_clear();
    pending_words.push_back(make_word(MODE_CLEAR, rnd(127), rnd(127), rnd(65535),
                                      rnd(127), rnd(127)));
  endtask

  // Stimulus: directed cases, then random small graphs.
  initial begin
    int nodes [5];
    int edge_from [$];
    int edge_to [$];
    int f, t, n_edges;
    bit dup;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) resid[i][j] = 0;

    // Single full-capacity edge from node 0 to node 127; flow is computed both ways.
    add_load(0, 127, 65535);
    add_compute(0, 127);
    add_compute(0, 127);
    add_compute(127, 0);
    // Self edge ends cleared; source equal to sink is flagged.
    add_load(5, 5, 65535);
    add_compute(5, 5);
    add_compute(127, 127);
    pending_words.push_back(make_word(MODE_IGNORED, 3, 4, 65535, 3, 4));
    add_load(7'h55, 7'h2A, 0);
    add_compute(1, 2);
    // Diamond with a cross edge.
    add_load(10, 11, 3);
    add_load(10, 12, 2);
    add_load(11, 13, 2);
    add_load(12, 13, 3);
    add_load(11, 12, 1);
    add_compute(10, 13);
    add_compute(13, 10);
    add_clear();
    add_compute(0, 127);

    // Random graphs on a few nodes; earlier edges are zeroed before each one.
    while (pending_words.size() < 1500) begin
      for (int e = 0; e < edge_from.size(); e++) add_load(edge_from[e], edge_to[e], 0);
      edge_from.delete();
      edge_to.delete();
      if (rnd(19) == 0) add_clear();
      for (int i = 0; i < 5; i++) begin
        do begin
          nodes[i] = rnd(127);
          dup = 0;
          for (int j = 0; j < i; j++) if (nodes[j] == nodes[i]) dup = 1;
        end while (dup);
      end
      n_edges = $urandom_range(4, 10);
      for (int e = 0; e < n_edges; e++) begin
        f = nodes[rnd(4)];
        t = nodes[rnd(4)];
        edge_from.push_back(f);
        edge_to.push_back(t);
        add_load(f, t, $urandom_range(0, 7));
        // Noise: self edges with any capacity, ignored words, flagged requests.
        case (rnd(9))
          0: begin
            f = rnd(127);
            add_load(f, f, rnd(65535));
          end
          1: pending_words.push_back(make_word(MODE_IGNORED, rnd(127), rnd(127),
                                               rnd(65535), rnd(127), rnd(127)));
          2: begin
            f = rnd(127);
            add_compute(f, f);
          end
          default: ;
        endcase
      end
      add_compute(nodes[0], nodes[rnd(3) + 1]);
      if (rnd(1)) add_compute(nodes[rnd(4)], nodes[rnd(4)]);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (flow_expect.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d compute requests among clears and edge loads on small random graphs,",
             computes_sent);
    $display("with random idling, one long output hold-off, and %0d mismatches.", mismatches);
    if (mismatches == 0 && flow_expect.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: max_flow_dfs_augment.f
rtl/core/mfa_pkg.sv
rtl/core/mfa_alu.sv
rtl/core/max_flow_dfs_augment.sv
bench/tb_top.sv
